@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants and types for the stream find-and-replace block
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_ALL        = 3'd4;

    // window row control, common to all cells
    typedef struct packed {
        logic load;
        logic shift;
    } win_ctrl_t;

endpackage

@@ rtl/sfr_in_if.sv @@
// ----------------------------------------------------------------------------
// sfr_in_if
// input item channel: one text byte, an end marker or both per item
// ----------------------------------------------------------------------------
interface sfr_in_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_byte_valid;
    logic              in_end;

    modport source (output valid, output in_byte, output in_byte_valid, output in_end,
                    input ready);
    modport sink   (input valid, input in_byte, input in_byte_valid, input in_end,
                    output ready);
endinterface

@@ rtl/sfr_out_if.sv @@
// ----------------------------------------------------------------------------
// sfr_out_if
// result item channel: one output byte, an end marker or both per item
// ----------------------------------------------------------------------------
interface sfr_out_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_byte_valid;
    logic              out_end;
    logic              run_last;

    modport source (output valid, output out_byte, output out_byte_valid, output out_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input out_byte_valid, input out_end,
                    input run_last, output ready);
endinterface

@@ rtl/sfr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sfr_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface sfr_cfg_if;
    import sfr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sfr_win_cell.sv @@
// ----------------------------------------------------------------------------
// sfr_win_cell
// one window position: holds a pending byte, merges the incoming byte and
// compares against its pattern byte
// ----------------------------------------------------------------------------
module sfr_win_cell #(
    parameter int IDX  = 0,
    parameter int WC_W = 4
) (
    input  logic                      clk,
    input  sfr_pkg::win_ctrl_t        ctrl,
    input  logic [WC_W-1:0]           wc,
    input  logic [sfr_pkg::BYTE_W-1:0] in_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] pat_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] nbr_cur,
    output logic [sfr_pkg::BYTE_W-1:0] cur,
    output logic                      eq
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // window contents with the new byte appended
    assign cur = (WC_W'(IDX) < wc) ? byte_reg : in_byte;
    assign eq  = (cur == pat_byte);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = nbr_cur;
        end
        else if (ctrl.load)
        begin
            byte_next = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

@@ rtl/sfr_out_cell.sv @@
// ----------------------------------------------------------------------------
// sfr_out_cell
// one slot of the result burst: loads a result byte and shifts toward the
// output port
// ----------------------------------------------------------------------------
module sfr_out_cell (
    input  logic                       clk,
    input  logic                       load,
    input  logic                       shift,
    input  logic [sfr_pkg::BYTE_W-1:0] load_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] nbr_byte,
    output logic [sfr_pkg::BYTE_W-1:0] cur
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    assign cur = byte_reg;

    always_comb
    begin
        byte_next = byte_reg;
        if (load)
        begin
            byte_next = load_byte;
        end
        else if (shift)
        begin
            byte_next = nbr_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

@@ rtl/stream_find_and_replace.sv @@
// ----------------------------------------------------------------------------
// stream_find_and_replace
// scans a byte stream for a pattern and substitutes a replacement string
// ----------------------------------------------------------------------------
// Bytes enter one per item into a row of window cells, each comparing its
// byte with one pattern byte. Every accepted item loads its results (released
// byte, replacement string, flushed tail or bare end marker) into a row of
// output cells that shifts one result out per cycle while dst is ready, so
// plain text streams at one byte per clock unless the output stalls; an item
// with several results holds the output row until the last is taken, and the
// next item is accepted in the cycle its last result is taken.
// The configuration port is always ready; write it only while the block is
// idle. Writing pattern_length discards any pending window bytes.
module stream_find_and_replace #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sfr_cfg_if.sink   cfg,
    sfr_in_if.sink    src,
    sfr_out_if.source dst
);
    import sfr_pkg::*;

    localparam int BURST_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int WC_W      = $clog2(PATTERN_MAX + 1);
    localparam int RC_W      = $clog2(REPLACE_MAX + 1);
    localparam int BC_W      = $clog2(BURST_MAX + 1);

    // configuration
    logic [CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] replacement_bytes_reg;
    logic [LEN_W-1:0]      replacement_length_reg;
    logic                  replace_all_reg;

    // control state
    logic [WC_W-1:0] wc_reg;
    logic [WC_W-1:0] wc_next;
    logic            replaced_reg;
    logic            replaced_next;
    logic [BC_W-1:0] cnt_reg;
    logic [BC_W-1:0] cnt_next;
    logic            end_reg;
    logic            end_next;
    logic            bare_reg;
    logic            bare_next;

    logic              cfg_wr;
    logic              accept;
    logic              pop;
    logic [WC_W-1:0]   plen;
    logic [RC_W-1:0]   rlen;
    logic              active;
    logic [WC_W-1:0]   nc;
    logic              full;
    logic              match_all;
    logic              hit;
    logic [BC_W-1:0]   run_len;
    logic              bare;
    win_ctrl_t         win_ctrl;

    logic [BYTE_W-1:0] win_cur [PATTERN_MAX];
    logic [BYTE_W-1:0] win_nbr [PATTERN_MAX];
    logic              win_eq  [PATTERN_MAX];
    logic [BYTE_W-1:0] slot    [BURST_MAX];
    logic [BYTE_W-1:0] out_cur [BURST_MAX];
    logic [BYTE_W-1:0] out_nbr [BURST_MAX];

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign accept    = src.valid && src.ready;
    assign pop       = dst.valid && dst.ready;

    assign src.ready = (cnt_reg == '0) || ((cnt_reg == BC_W'(1)) && dst.ready);

    assign plen = (pattern_length_reg > LEN_W'(PATTERN_MAX)) ? WC_W'(PATTERN_MAX)
                                                             : WC_W'(pattern_length_reg);
    assign rlen = (replacement_length_reg > LEN_W'(REPLACE_MAX)) ? RC_W'(REPLACE_MAX)
                                                                 : RC_W'(replacement_length_reg);
    assign active = (plen != '0) && !(!replace_all_reg && replaced_reg);
    assign nc     = wc_reg + WC_W'(src.in_byte_valid);
    assign full   = active && src.in_byte_valid && (nc == plen);

    always_comb
    begin
        match_all = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if ((WC_W'(k) < plen) && !win_eq[k])
            begin
                match_all = 1'b0;
            end
        end
    end

    assign hit = full && match_all;

    // number of results for the item
    always_comb
    begin
        if (!active)
        begin
            run_len = BC_W'(nc);
        end
        else if (hit)
        begin
            run_len = BC_W'(rlen);
        end
        else if (full)
        begin
            run_len = src.in_end ? BC_W'(nc) : BC_W'(1);
        end
        else
        begin
            run_len = src.in_end ? BC_W'(nc) : '0;
        end
        bare = src.in_end && (run_len == '0);
        if (bare)
        begin
            run_len = BC_W'(1);
        end
    end

    assign win_ctrl.load  = accept && active && src.in_byte_valid && !src.in_end && !full;
    assign win_ctrl.shift = accept && full && !hit && !src.in_end;

    // window row
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_win
        if (k + 1 < PATTERN_MAX)
        begin : g_nbr
            assign win_nbr[k] = win_cur[k+1];
        end
        else
        begin : g_last
            assign win_nbr[k] = win_cur[k];
        end

        sfr_win_cell #(
            .IDX  (k),
            .WC_W (WC_W)
        ) u_cell (
            .clk      (clk),
            .ctrl     (win_ctrl),
            .wc       (wc_reg),
            .in_byte  (src.in_byte),
            .pat_byte (pattern_bytes_reg[BYTE_W*k +: BYTE_W]),
            .nbr_cur  (win_nbr[k]),
            .cur      (win_cur[k]),
            .eq       (win_eq[k])
        );
    end

    // result burst row
    for (genvar j = 0; j < BURST_MAX; j++)
    begin : g_out
        logic [BYTE_W-1:0] rep_b;
        logic [BYTE_W-1:0] win_b;

        if (j < REPLACE_MAX)
        begin : g_rep
            assign rep_b = replacement_bytes_reg[BYTE_W*j +: BYTE_W];
        end
        else
        begin : g_norep
            assign rep_b = '0;
        end

        if (j < PATTERN_MAX)
        begin : g_wb
            assign win_b = win_cur[j];
        end
        else
        begin : g_nowb
            assign win_b = '0;
        end

        assign slot[j] = bare ? '0 : (hit ? rep_b : win_b);

        if (j + 1 < BURST_MAX)
        begin : g_nbr
            assign out_nbr[j] = out_cur[j+1];
        end
        else
        begin : g_last
            assign out_nbr[j] = '0;
        end

        sfr_out_cell u_cell (
            .clk       (clk),
            .load      (accept),
            .shift     (pop),
            .load_byte (slot[j]),
            .nbr_byte  (out_nbr[j]),
            .cur       (out_cur[j])
        );
    end

    assign dst.valid          = (cnt_reg != '0);
    assign dst.out_byte       = out_cur[0];
    assign dst.out_byte_valid = !bare_reg;
    assign dst.run_last       = (cnt_reg == BC_W'(1));
    assign dst.out_end        = end_reg && (cnt_reg == BC_W'(1));

    always_comb
    begin
        wc_next       = wc_reg;
        replaced_next = replaced_reg;
        cnt_next      = cnt_reg;
        end_next      = end_reg;
        bare_next     = bare_reg;

        if (accept)
        begin
            cnt_next  = run_len;
            end_next  = src.in_end;
            bare_next = bare;
            if (!active || src.in_end || hit)
            begin
                wc_next = '0;
            end
            else if (full)
            begin
                wc_next = nc - WC_W'(1);
            end
            else
            begin
                wc_next = nc;
            end
            if (src.in_end)
            begin
                replaced_next = 1'b0;
            end
            else if (hit && !replace_all_reg)
            begin
                replaced_next = 1'b1;
            end
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - BC_W'(1);
        end

        if (cfg_wr && (cfg.index == CFG_PATTERN_LENGTH))
        begin
            wc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= '0;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
            replace_all_reg        <= 1'b1;
            wc_reg                 <= '0;
            replaced_reg           <= 1'b0;
            cnt_reg                <= '0;
            end_reg                <= 1'b0;
            bare_reg               <= 1'b0;
        end
        else
        begin
            wc_reg       <= wc_next;
            replaced_reg <= replaced_next;
            cnt_reg      <= cnt_next;
            end_reg      <= end_next;
            bare_reg     <= bare_next;
            if (cfg_wr)
            begin
                case (cfg.index)
                    CFG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg.data;
                    CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg.data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg.data;
                    CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg.data[LEN_W-1:0];
                    CFG_REPLACE_ALL:        replace_all_reg        <= cfg.data[0];
                    default:                ;
                endcase
            end
        end
    end

    // pending window is always shorter than the pattern while matching
    a_win_short: assert property (@(posedge clk) disable iff (!rst_n)
        active |-> (wc_reg < plen))
        else $error("window holds a full pattern between items");

    // burst never exceeds its row
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= BC_W'(BURST_MAX))
        else $error("result count beyond burst depth");

    // a bare marker only ever closes a string
    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && !dst.out_byte_valid) |-> (dst.out_end && dst.run_last))
        else $error("bare marker without end");

    // end of string is always the last result of its item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && dst.out_end) |-> dst.run_last)
        else $error("end marker not last of run");

    // an accepted item loads its result count into the burst counter
    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (cnt_reg == $past(run_len)))
        else $error("burst count not loaded on accept");

endmodule
